@@ src/rtfp_pkg.sv @@
// ----------------------------------------------------------------------------
// rtfp_pkg: shared types and constants for the radar target frame parser
// Item kinds, event codes, frame byte values and frame positions.
// ----------------------------------------------------------------------------
package rtfp_pkg;

  // Input mode codes as they arrive on the port
  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_ERROR = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_ERROR = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  data;
  } op_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_ACCEPT = 2'd1,
    EV_REJECT = 2'd2,
    EV_LINK   = 2'd3
  } event_t;

  // Frame byte values
  localparam logic [7:0] SYNC0      = 8'hF4;
  localparam logic [7:0] SYNC1      = 8'hF3;
  localparam logic [7:0] SYNC2      = 8'hF2;
  localparam logic [7:0] SYNC3      = 8'hF1;
  localparam logic [7:0] LEN_LO     = 8'h0D;
  localparam logic [7:0] LEN_HI     = 8'h00;
  localparam logic [7:0] TYPE_BASIC = 8'h02;
  localparam logic [7:0] HEAD_BYTE  = 8'hAA;
  localparam logic [7:0] TAIL_LO    = 8'h55;
  localparam logic [7:0] TAIL_HI    = 8'h00;
  localparam logic [7:0] FOOT0      = 8'hF8;
  localparam logic [7:0] FOOT1      = 8'hF7;
  localparam logic [7:0] FOOT2      = 8'hF6;
  localparam logic [7:0] FOOT3      = 8'hF5;
  localparam logic [7:0] STATE_MAX  = 8'd3;
  localparam logic [7:0] ENERGY_MAX = 8'd100;

  // Frame positions (index of the byte being received)
  localparam int unsigned POS_W = 5;
  localparam logic [POS_W-1:0] POS_HDR_END = 5'd4;
  localparam logic [POS_W-1:0] POS_LEN_LO  = 5'd4;
  localparam logic [POS_W-1:0] POS_LEN_HI  = 5'd5;
  localparam logic [POS_W-1:0] POS_TYPE    = 5'd6;
  localparam logic [POS_W-1:0] POS_HEAD    = 5'd7;
  localparam logic [POS_W-1:0] POS_STATE   = 5'd8;
  localparam logic [POS_W-1:0] POS_MV_LO   = 5'd9;
  localparam logic [POS_W-1:0] POS_MV_HI   = 5'd10;
  localparam logic [POS_W-1:0] POS_MV_EN   = 5'd11;
  localparam logic [POS_W-1:0] POS_ST_LO   = 5'd12;
  localparam logic [POS_W-1:0] POS_ST_HI   = 5'd13;
  localparam logic [POS_W-1:0] POS_ST_EN   = 5'd14;
  localparam logic [POS_W-1:0] POS_TAIL_LO = 5'd17;
  localparam logic [POS_W-1:0] POS_TAIL_HI = 5'd18;
  localparam logic [POS_W-1:0] POS_FOOT0   = 5'd19;
  localparam logic [POS_W-1:0] POS_FOOT1   = 5'd20;
  localparam logic [POS_W-1:0] POS_FOOT2   = 5'd21;
  localparam logic [POS_W-1:0] POS_LAST    = 5'd22;
  localparam logic [POS_W-1:0] FRAME_LEN   = 5'd23;

  localparam int unsigned AGE_W = 17;
  localparam logic [AGE_W-1:0] AGE_MAX = 17'h1FFFF;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1500;

  function automatic logic [7:0] sync_byte(input logic [1:0] idx);
    logic [7:0] r;
    begin
      case (idx)
        2'd0:    r = SYNC0;
        2'd1:    r = SYNC1;
        2'd2:    r = SYNC2;
        default: r = SYNC3;
      endcase
      return r;
    end
  endfunction

endpackage

@@ src/rtfp_front.sv @@
// ----------------------------------------------------------------------------
// rtfp_front: input side of the frame parser
// Accepts input words, classifies them into operations and queues them
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rtfp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     mode,
  input  logic [7:0]     data_byte,
  output logic           q_valid,
  input  logic           q_ready,
  output rtfp_pkg::op_t  q_op
);

  rtfp_pkg::op_t op_in;
  rtfp_pkg::op_t slots [2];
  logic [1:0]    count;
  logic          wr_ptr;
  logic          rd_ptr;
  logic          push;
  logic          pop;

  always_comb begin
    op_in.data = data_byte;
    case (mode)
      rtfp_pkg::MODE_BYTE:  op_in.kind = rtfp_pkg::OP_BYTE;
      rtfp_pkg::MODE_ERROR: op_in.kind = rtfp_pkg::OP_ERROR;
      rtfp_pkg::MODE_TICK:  op_in.kind = rtfp_pkg::OP_TICK;
      default:              op_in.kind = rtfp_pkg::OP_NONE;
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_op     = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/rtfp_back.sv @@
// ----------------------------------------------------------------------------
// rtfp_back: execution side of the frame parser
// Runs the byte sync parser, target hold and age logic and the counters,
// one queued operation per cycle while results are taken, into a registered result.
// ----------------------------------------------------------------------------
module rtfp_back #(
  parameter int unsigned COUNTER_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  rtfp_pkg::op_t           q_op,
  input  logic [15:0]             online_timeout_ms,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              event_code,
  output logic [1:0]              target_state,
  output logic [15:0]             distance_cm,
  output logic [15:0]             moving_distance_cm,
  output logic [6:0]              moving_energy,
  output logic [15:0]             still_distance_cm,
  output logic [6:0]              still_energy,
  output logic                    online,
  output logic                    presence,
  output logic [COUNTER_BITS-1:0] good_cnt,
  output logic [COUNTER_BITS-1:0] bad_cnt,
  output logic [COUNTER_BITS-1:0] err_cnt
);

  localparam int unsigned PW = rtfp_pkg::POS_W;
  localparam int unsigned AW = rtfp_pkg::AGE_W;

  logic                    pop;
  rtfp_pkg::event_t        ev, ev_next;
  logic [PW-1:0]           pos, pos_next;
  logic                    len_ok, len_ok_next;
  logic                    body_ok, body_ok_next;
  logic [1:0]              cap_state, cap_state_next;
  logic [15:0]             cap_mv, cap_mv_next;
  logic [15:0]             cap_st, cap_st_next;
  logic [6:0]              cap_mve, cap_mve_next;
  logic [6:0]              cap_ste, cap_ste_next;
  logic [1:0]              held_state, held_state_next;
  logic [15:0]             held_dist, held_dist_next;
  logic [15:0]             held_mv, held_mv_next;
  logic [15:0]             held_st, held_st_next;
  logic [6:0]              held_mve, held_mve_next;
  logic [6:0]              held_ste, held_ste_next;
  logic [AW-1:0]           age, age_next;
  logic                    seen, seen_next;
  logic [COUNTER_BITS-1:0] good, good_next;
  logic [COUNTER_BITS-1:0] bad, bad_next;
  logic [COUNTER_BITS-1:0] errs, errs_next;
  logic [7:0]              b;

  function automatic logic [15:0] pick_distance(input logic [1:0] st_code,
                                                input logic [15:0] mv,
                                                input logic [15:0] sd);
    logic [15:0] r;
    begin
      case (st_code)
        2'd1: r = mv;
        2'd2: r = sd;
        2'd3: begin
          if (mv == 16'd0) begin
            r = sd;
          end else if (sd == 16'd0) begin
            r = mv;
          end else begin
            r = (mv < sd) ? mv : sd;
          end
        end
        default: r = 16'd0;
      endcase
      return r;
    end
  endfunction

  assign q_ready = !out_valid || out_ready;
  assign pop     = q_valid && q_ready;
  assign b       = q_op.data;

  always_comb begin
    ev_next         = rtfp_pkg::EV_NONE;
    pos_next        = pos;
    len_ok_next     = len_ok;
    body_ok_next    = body_ok;
    cap_state_next  = cap_state;
    cap_mv_next     = cap_mv;
    cap_st_next     = cap_st;
    cap_mve_next    = cap_mve;
    cap_ste_next    = cap_ste;
    held_state_next = held_state;
    held_dist_next  = held_dist;
    held_mv_next    = held_mv;
    held_st_next    = held_st;
    held_mve_next   = held_mve;
    held_ste_next   = held_ste;
    age_next        = age;
    seen_next       = seen;
    good_next       = good;
    bad_next        = bad;
    errs_next       = errs;

    case (q_op.kind)
      rtfp_pkg::OP_BYTE: begin
        if (pos < rtfp_pkg::POS_HDR_END) begin
          if (b == rtfp_pkg::sync_byte(pos[1:0])) begin
            pos_next = pos + PW'(1);
          end else if (b == rtfp_pkg::SYNC0) begin
            pos_next = PW'(1);
          end else begin
            pos_next = '0;
          end
        end else if (pos >= rtfp_pkg::FRAME_LEN) begin
          pos_next = '0;
        end else begin
          pos_next = pos + PW'(1);
          case (pos)
            rtfp_pkg::POS_LEN_LO: len_ok_next = (b == rtfp_pkg::LEN_LO);
            rtfp_pkg::POS_LEN_HI: begin
              if (!(len_ok && (b == rtfp_pkg::LEN_HI))) begin
                ev_next  = rtfp_pkg::EV_REJECT;
                bad_next = bad + COUNTER_BITS'(1);
                pos_next = '0;
              end
            end
            rtfp_pkg::POS_TYPE: body_ok_next = (b == rtfp_pkg::TYPE_BASIC);
            rtfp_pkg::POS_HEAD: body_ok_next = body_ok && (b == rtfp_pkg::HEAD_BYTE);
            rtfp_pkg::POS_STATE: begin
              body_ok_next   = body_ok && (b <= rtfp_pkg::STATE_MAX);
              cap_state_next = b[1:0];
            end
            rtfp_pkg::POS_MV_LO: cap_mv_next[7:0]  = b;
            rtfp_pkg::POS_MV_HI: cap_mv_next[15:8] = b;
            rtfp_pkg::POS_MV_EN: begin
              body_ok_next = body_ok && (b <= rtfp_pkg::ENERGY_MAX);
              cap_mve_next = b[6:0];
            end
            rtfp_pkg::POS_ST_LO: cap_st_next[7:0]  = b;
            rtfp_pkg::POS_ST_HI: cap_st_next[15:8] = b;
            rtfp_pkg::POS_ST_EN: begin
              body_ok_next = body_ok && (b <= rtfp_pkg::ENERGY_MAX);
              cap_ste_next = b[6:0];
            end
            rtfp_pkg::POS_TAIL_LO: body_ok_next = body_ok && (b == rtfp_pkg::TAIL_LO);
            rtfp_pkg::POS_TAIL_HI: body_ok_next = body_ok && (b == rtfp_pkg::TAIL_HI);
            rtfp_pkg::POS_FOOT0:   body_ok_next = body_ok && (b == rtfp_pkg::FOOT0);
            rtfp_pkg::POS_FOOT1:   body_ok_next = body_ok && (b == rtfp_pkg::FOOT1);
            rtfp_pkg::POS_FOOT2:   body_ok_next = body_ok && (b == rtfp_pkg::FOOT2);
            rtfp_pkg::POS_LAST: begin
              pos_next = '0;
              if (body_ok && (b == rtfp_pkg::FOOT3)) begin
                ev_next         = rtfp_pkg::EV_ACCEPT;
                held_state_next = cap_state;
                held_mv_next    = cap_mv;
                held_st_next    = cap_st;
                held_mve_next   = cap_mve;
                held_ste_next   = cap_ste;
                held_dist_next  = pick_distance(cap_state, cap_mv, cap_st);
                age_next        = '0;
                seen_next       = 1'b1;
                good_next       = good + COUNTER_BITS'(1);
              end else begin
                ev_next  = rtfp_pkg::EV_REJECT;
                bad_next = bad + COUNTER_BITS'(1);
              end
            end
            default: ;
          endcase
        end
      end
      rtfp_pkg::OP_ERROR: begin
        ev_next   = rtfp_pkg::EV_LINK;
        errs_next = errs + COUNTER_BITS'(1);
        pos_next  = '0;
      end
      rtfp_pkg::OP_TICK: begin
        if (age != rtfp_pkg::AGE_MAX) begin
          age_next = age + AW'(1);
        end
        // drop the target once the age runs past the timeout
        if (seen && (age_next > {1'b0, online_timeout_ms})) begin
          held_state_next = '0;
          held_dist_next  = '0;
          held_mv_next    = '0;
          held_st_next    = '0;
          held_mve_next   = '0;
          held_ste_next   = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      ev         <= rtfp_pkg::EV_NONE;
      pos        <= '0;
      held_state <= '0;
      held_dist  <= '0;
      held_mv    <= '0;
      held_st    <= '0;
      held_mve   <= '0;
      held_ste   <= '0;
      age        <= '0;
      seen       <= 1'b0;
      good       <= '0;
      bad        <= '0;
      errs       <= '0;
    end else begin
      if (pop) begin
        out_valid  <= 1'b1;
        ev         <= ev_next;
        pos        <= pos_next;
        held_state <= held_state_next;
        held_dist  <= held_dist_next;
        held_mv    <= held_mv_next;
        held_st    <= held_st_next;
        held_mve   <= held_mve_next;
        held_ste   <= held_ste_next;
        age        <= age_next;
        seen       <= seen_next;
        good       <= good_next;
        bad        <= bad_next;
        errs       <= errs_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // frame capture: written within the current frame before it is read
  always_ff @(posedge clk) begin
    if (pop) begin
      len_ok    <= len_ok_next;
      body_ok   <= body_ok_next;
      cap_state <= cap_state_next;
      cap_mv    <= cap_mv_next;
      cap_st    <= cap_st_next;
      cap_mve   <= cap_mve_next;
      cap_ste   <= cap_ste_next;
    end
  end

  assign event_code         = ev;
  assign target_state       = held_state;
  assign distance_cm        = held_dist;
  assign moving_distance_cm = held_mv;
  assign moving_energy      = held_mve;
  assign still_distance_cm  = held_st;
  assign still_energy       = held_ste;
  assign online             = seen && (age <= {1'b0, online_timeout_ms});
  assign presence           = online && (held_state != 2'd0);
  assign good_cnt           = good;
  assign bad_cnt            = bad;
  assign err_cnt            = errs;

endmodule

@@ src/radar_target_frame_parser.sv @@
// ----------------------------------------------------------------------------
// radar_target_frame_parser: basic-target frame parser for a radar sensor
// Parses the serial frame stream, holds the latest target report, ages it
// out on millisecond ticks and counts good, bad and link-error events.
// ----------------------------------------------------------------------------
// Each input word is a received byte (mode 0), a receive error (mode 1) or a
// one-millisecond tick (mode 2); mode 3 is ignored but still answered. Every
// accepted word gives exactly one result word carrying the event code and
// the full state after the update. The block takes one word per cycle while
// its results are taken: the front end queues words in a two-entry queue and
// the back end retires one queued word per cycle into its output register,
// so throughput is one word per clock when the output does not stall. The
// queue lets the input keep flowing while a result waits, until it is full.
// Frames are 23 bytes: header F4 F3 F2 F1, length 0D 00, type 02, head AA,
// state, moving distance (LE16), moving energy, still distance (LE16), still
// energy, two free bytes, tail 55 00, footer F8 F7 F6 F5. A bad length is
// rejected at the sixth byte; any other fault is rejected at the last byte.
// Write online_timeout_ms only while no word is in flight.
// ----------------------------------------------------------------------------
module radar_target_frame_parser #(
  parameter int unsigned COUNTER_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  data_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_code,
  output logic [1:0]  target_state,
  output logic [15:0] distance_cm,
  output logic [15:0] moving_distance_cm,
  output logic [6:0]  moving_energy,
  output logic [15:0] still_distance_cm,
  output logic [6:0]  still_energy,
  output logic        online,
  output logic        presence,
  output logic [31:0] good_frames,
  output logic [31:0] bad_frames,
  output logic [31:0] link_errors,
  // timeout register write
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic                    q_valid;
  logic                    q_ready;
  rtfp_pkg::op_t           q_op;
  logic [15:0]             online_timeout_ms;
  logic [COUNTER_BITS-1:0] good_cnt;
  logic [COUNTER_BITS-1:0] bad_cnt;
  logic [COUNTER_BITS-1:0] err_cnt;

  // hold the timeout register; the user writes it only while idle, the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      online_timeout_ms <= rtfp_pkg::TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      online_timeout_ms <= cfg_wr_data;
    end
  end

  // classify and queue incoming words
  rtfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .data_byte (data_byte),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_op      (q_op)
  );

  // parse, age and count, one queued word per cycle while results are taken
  rtfp_back #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .q_valid            (q_valid),
    .q_ready            (q_ready),
    .q_op               (q_op),
    .online_timeout_ms  (online_timeout_ms),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .event_code         (event_code),
    .target_state       (target_state),
    .distance_cm        (distance_cm),
    .moving_distance_cm (moving_distance_cm),
    .moving_energy      (moving_energy),
    .still_distance_cm  (still_distance_cm),
    .still_energy       (still_energy),
    .online             (online),
    .presence           (presence),
    .good_cnt           (good_cnt),
    .bad_cnt            (bad_cnt),
    .err_cnt            (err_cnt)
  );

  // resize the wrapping counters to the port width (zero-extend or truncate)
  assign good_frames = 32'(good_cnt);
  assign bad_frames  = 32'(bad_cnt);
  assign link_errors = 32'(err_cnt);

endmodule

@@ src/rtfp_checker.sv @@
// ----------------------------------------------------------------------------
// rtfp_checker: port-level checks for the radar target frame parser
// Watches the top-level ports and flags broken result rules.
// ----------------------------------------------------------------------------
module rtfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  event_code,
  input logic [1:0]  target_state,
  input logic [15:0] distance_cm,
  input logic        online,
  input logic        presence
);

  // result stalled: hold it
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_code))
    else $error("result changed while stalled");

  a_presence_online: assert property (@(posedge clk) disable iff (rst)
    out_valid && presence |-> online && (target_state != 2'd0))
    else $error("presence without online target");

  a_accept_online: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_code == rtfp_pkg::EV_ACCEPT) |-> online)
    else $error("accepted frame but offline");

  a_no_target_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && (target_state == 2'd0) |-> (distance_cm == 16'd0))
    else $error("distance reported with no target");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind radar_target_frame_parser rtfp_checker u_rtfp_checker (.*);

@@ sim/tb_radar_target_frame_parser.sv @@
// ----------------------------------------------------------------------------
// tb_radar_target_frame_parser: self-checking bench for the frame parser
// Drives bytes, receive errors and millisecond ticks through the valid/ready
// input, keeps a cycle-free model of the parser and its held target report,
// and compares every result word field by field under random back-pressure.
// ----------------------------------------------------------------------------
module tb_radar_target_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any handshake before the run is declared hung. The
  // longest planned quiet stretch is the receiver hold-off.
  localparam int STUCK_LIMIT = 5000;
  localparam int PRINT_LIMIT = 40;

  // Header bytes in order, entry 0 first on the wire.
  localparam logic [3:0][7:0] HEADER = {rtfp_pkg::SYNC3, rtfp_pkg::SYNC2,
                                        rtfp_pkg::SYNC1, rtfp_pkg::SYNC0};

  typedef struct packed {
    rtfp_pkg::event_t ev;
    logic [1:0]  tgt_state;
    logic [15:0] dist_cm;
    logic [15:0] mv_dist;
    logic [6:0]  mv_en;
    logic [15:0] st_dist;
    logic [6:0]  st_en;
    logic        online;
    logic        presence;
    logic [31:0] good;
    logic [31:0] bad;
    logic [31:0] link;
  } report_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  mode;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  event_code;
  logic [1:0]  target_state;
  logic [15:0] distance_cm;
  logic [15:0] moving_distance_cm;
  logic [6:0]  moving_energy;
  logic [15:0] still_distance_cm;
  logic [6:0]  still_energy;
  logic        online;
  logic        presence;
  logic [31:0] good_frames;
  logic [31:0] bad_frames;
  logic [31:0] link_errors;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  // Model of the parser: position, captured bytes, held report, age, counters
  logic [4:0]  parse_pos = '0;
  logic [7:0]  frame_copy [0:rtfp_pkg::FRAME_LEN-1];
  logic [1:0]  held_state = '0;
  logic [15:0] held_dist = '0;
  logic [15:0] held_mv_dist = '0;
  logic [15:0] held_st_dist = '0;
  logic [6:0]  held_mv_en = '0;
  logic [6:0]  held_st_en = '0;
  logic [16:0] age_ms = '0;
  logic        seen_good = 1'b0;
  logic [31:0] good_total = '0;
  logic [31:0] bad_total = '0;
  logic [31:0] link_total = '0;
  logic [15:0] limit_ms = rtfp_pkg::TIMEOUT_RESET;

  report_t     pending_reports [$];
  logic [7:0]  frame_buf [0:rtfp_pkg::FRAME_LEN-1];

  int          mismatches = 0;
  int          results_seen = 0;
  int          words_sent = 0;
  int          stuck_cycles = 0;
  int          hold_request = 0;
  int          hold_left = 0;
  bit          no_gaps_in = 1'b0;
  bit          no_gaps_out = 1'b0;

  radar_target_frame_parser uut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .mode               (mode),
    .data_byte          (data_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .event_code         (event_code),
    .target_state       (target_state),
    .distance_cm        (distance_cm),
    .moving_distance_cm (moving_distance_cm),
    .moving_energy      (moving_energy),
    .still_distance_cm  (still_distance_cm),
    .still_energy       (still_energy),
    .online             (online),
    .presence           (presence),
    .good_frames        (good_frames),
    .bad_frames         (bad_frames),
    .link_errors        (link_errors),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------

  // Advance the frame parser by one received byte and return its event.
  task automatic parse_byte(input logic [7:0] b, output rtfp_pkg::event_t ev);
    logic body_ok;
    ev = rtfp_pkg::EV_NONE;
    if (parse_pos < rtfp_pkg::POS_HDR_END) begin
      // Hunt for the header; a stray F4 may itself open a new header.
      if (b == HEADER[parse_pos[1:0]]) begin
        frame_copy[parse_pos] = b;
        parse_pos = parse_pos + 5'd1;
      end else if (b == rtfp_pkg::SYNC0) begin
        frame_copy[0] = b;
        parse_pos = 5'd1;
      end else begin
        parse_pos = '0;
      end
    end else if (parse_pos >= rtfp_pkg::FRAME_LEN) begin
      parse_pos = '0;
    end else begin
      frame_copy[parse_pos] = b;
      parse_pos = parse_pos + 5'd1;
      if (parse_pos == rtfp_pkg::POS_TYPE) begin
        // Both length bytes are in: drop the frame right here if wrong.
        if (frame_copy[rtfp_pkg::POS_LEN_LO] != rtfp_pkg::LEN_LO ||
            frame_copy[rtfp_pkg::POS_LEN_HI] != rtfp_pkg::LEN_HI) begin
          bad_total = bad_total + 32'd1;
          parse_pos = '0;
          ev = rtfp_pkg::EV_REJECT;
        end
      end else if (parse_pos == rtfp_pkg::FRAME_LEN) begin
        parse_pos = '0;
        body_ok = frame_copy[rtfp_pkg::POS_TYPE] == rtfp_pkg::TYPE_BASIC &&
                  frame_copy[rtfp_pkg::POS_HEAD] == rtfp_pkg::HEAD_BYTE &&
                  frame_copy[rtfp_pkg::POS_STATE] <= rtfp_pkg::STATE_MAX &&
                  frame_copy[rtfp_pkg::POS_MV_EN] <= rtfp_pkg::ENERGY_MAX &&
                  frame_copy[rtfp_pkg::POS_ST_EN] <= rtfp_pkg::ENERGY_MAX &&
                  frame_copy[rtfp_pkg::POS_TAIL_LO] == rtfp_pkg::TAIL_LO &&
                  frame_copy[rtfp_pkg::POS_TAIL_HI] == rtfp_pkg::TAIL_HI &&
                  frame_copy[rtfp_pkg::POS_FOOT0] == rtfp_pkg::FOOT0 &&
                  frame_copy[rtfp_pkg::POS_FOOT1] == rtfp_pkg::FOOT1 &&
                  frame_copy[rtfp_pkg::POS_FOOT2] == rtfp_pkg::FOOT2 &&
                  frame_copy[rtfp_pkg::POS_LAST] == rtfp_pkg::FOOT3;
        if (!body_ok) begin
          bad_total = bad_total + 32'd1;
          ev = rtfp_pkg::EV_REJECT;
        end else begin
          held_state   = frame_copy[rtfp_pkg::POS_STATE][1:0];
          held_mv_dist = {frame_copy[rtfp_pkg::POS_MV_HI], frame_copy[rtfp_pkg::POS_MV_LO]};
          held_st_dist = {frame_copy[rtfp_pkg::POS_ST_HI], frame_copy[rtfp_pkg::POS_ST_LO]};
          held_mv_en   = frame_copy[rtfp_pkg::POS_MV_EN][6:0];
          held_st_en   = frame_copy[rtfp_pkg::POS_ST_EN][6:0];
          // Pick the reported distance; with both targets take the
          // nonzero one, or the nearer when both are present.
          case (held_state)
            2'd1: held_dist = held_mv_dist;
            2'd2: held_dist = held_st_dist;
            2'd3: begin
              if (held_mv_dist == 16'd0)
                held_dist = held_st_dist;
              else if (held_st_dist == 16'd0)
                held_dist = held_mv_dist;
              else
                held_dist = (held_mv_dist < held_st_dist) ? held_mv_dist : held_st_dist;
            end
            default: held_dist = 16'd0;
          endcase
          age_ms = '0;
          seen_good = 1'b1;
          good_total = good_total + 32'd1;
          ev = rtfp_pkg::EV_ACCEPT;
        end
      end
    end
  endtask

  // Apply one accepted word to the model and queue the result it must give.
  task automatic predict_report(input rtfp_pkg::op_kind_t kind, input logic [7:0] b);
    report_t          r;
    rtfp_pkg::event_t ev;
    ev = rtfp_pkg::EV_NONE;
    case (kind)
      rtfp_pkg::OP_BYTE: parse_byte(b, ev);
      rtfp_pkg::OP_ERROR: begin
        link_total = link_total + 32'd1;
        parse_pos = '0;
        ev = rtfp_pkg::EV_LINK;
      end
      rtfp_pkg::OP_TICK: begin
        if (age_ms < rtfp_pkg::AGE_MAX)
          age_ms = age_ms + 17'd1;
        // Age out the held report; the counters and the parser survive.
        if (seen_good && age_ms > {1'b0, limit_ms}) begin
          held_state   = '0;
          held_dist    = '0;
          held_mv_dist = '0;
          held_st_dist = '0;
          held_mv_en   = '0;
          held_st_en   = '0;
        end
      end
      default: ;
    endcase
    r.ev        = ev;
    r.tgt_state = held_state;
    r.dist_cm   = held_dist;
    r.mv_dist   = held_mv_dist;
    r.mv_en     = held_mv_en;
    r.st_dist   = held_st_dist;
    r.st_en     = held_st_en;
    r.online    = seen_good && (age_ms <= {1'b0, limit_ms});
    r.presence  = r.online && (held_state != 2'd0);
    r.good      = good_total;
    r.bad       = bad_total;
    r.link      = link_total;
    pending_reports.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("[%0t] result %0d: %s got %0h, expected %0h",
               $realtime, results_seen, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch(what, got, want);
  endtask

  task automatic compare_report(input report_t want);
    check_field("event_code", 32'(event_code), 32'(want.ev));
    check_field("target_state", 32'(target_state), 32'(want.tgt_state));
    check_field("distance_cm", 32'(distance_cm), 32'(want.dist_cm));
    check_field("moving_distance_cm", 32'(moving_distance_cm), 32'(want.mv_dist));
    check_field("moving_energy", 32'(moving_energy), 32'(want.mv_en));
    check_field("still_distance_cm", 32'(still_distance_cm), 32'(want.st_dist));
    check_field("still_energy", 32'(still_energy), 32'(want.st_en));
    check_field("online", 32'(online), 32'(want.online));
    check_field("presence", 32'(presence), 32'(want.presence));
    check_field("good_frames", good_frames, want.good);
    check_field("bad_frames", bad_frames, want.bad);
    check_field("link_errors", link_errors, want.link);
  endtask

  // Sample the result channel at the edge; pop the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      results_seen++;
      if (pending_reports.size() == 0)
        report_mismatch("result with nothing pending, event_code", 32'(event_code), 32'd0);
      else
        compare_report(pending_reports.pop_front());
    end
  end

  // Receiver: random stalls, gap-free stretches, and a long hold-off on request.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_gaps_out || ($urandom_range(99) >= 12);
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offer one word, holding it until accepted; gaps are inserted before it.
  task automatic send_word(input rtfp_pkg::op_kind_t kind, input logic [7:0] b);
    while (!no_gaps_in && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= kind;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    predict_report(kind, b);
    if (kind != rtfp_pkg::OP_NONE)
      words_sent++;
  endtask

  // Drop valid and wait until every queued result is back, plus pipeline slack.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    limit_ms = value;
  endtask

  task automatic build_frame(input logic [7:0] tstate, input logic [15:0] mv,
                             input logic [7:0] mv_en, input logic [15:0] sd,
                             input logic [7:0] sd_en);
    frame_buf[0]                         = rtfp_pkg::SYNC0;
    frame_buf[1]                         = rtfp_pkg::SYNC1;
    frame_buf[2]                         = rtfp_pkg::SYNC2;
    frame_buf[3]                         = rtfp_pkg::SYNC3;
    frame_buf[rtfp_pkg::POS_LEN_LO]      = rtfp_pkg::LEN_LO;
    frame_buf[rtfp_pkg::POS_LEN_HI]      = rtfp_pkg::LEN_HI;
    frame_buf[rtfp_pkg::POS_TYPE]        = rtfp_pkg::TYPE_BASIC;
    frame_buf[rtfp_pkg::POS_HEAD]        = rtfp_pkg::HEAD_BYTE;
    frame_buf[rtfp_pkg::POS_STATE]       = tstate;
    frame_buf[rtfp_pkg::POS_MV_LO]       = mv[7:0];
    frame_buf[rtfp_pkg::POS_MV_HI]       = mv[15:8];
    frame_buf[rtfp_pkg::POS_MV_EN]       = mv_en;
    frame_buf[rtfp_pkg::POS_ST_LO]       = sd[7:0];
    frame_buf[rtfp_pkg::POS_ST_HI]       = sd[15:8];
    frame_buf[rtfp_pkg::POS_ST_EN]       = sd_en;
    // the two spare bytes carry anything
    frame_buf[rtfp_pkg::POS_ST_EN + 5'd1] = 8'($urandom);
    frame_buf[rtfp_pkg::POS_ST_EN + 5'd2] = 8'($urandom);
    frame_buf[rtfp_pkg::POS_TAIL_LO]     = rtfp_pkg::TAIL_LO;
    frame_buf[rtfp_pkg::POS_TAIL_HI]     = rtfp_pkg::TAIL_HI;
    frame_buf[rtfp_pkg::POS_FOOT0]       = rtfp_pkg::FOOT0;
    frame_buf[rtfp_pkg::POS_FOOT1]       = rtfp_pkg::FOOT1;
    frame_buf[rtfp_pkg::POS_FOOT2]       = rtfp_pkg::FOOT2;
    frame_buf[rtfp_pkg::POS_LAST]        = rtfp_pkg::FOOT3;
  endtask

  // Well-formed frame; zero distances are favored to hit the both-targets rules.
  task automatic build_random_frame();
    logic [15:0] mv;
    logic [15:0] sd;
    mv = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
    sd = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
    build_frame(8'($urandom_range(3)), mv, 8'($urandom_range(100)),
                sd, 8'($urandom_range(100)));
  endtask

  task automatic send_frame_span(input int first, input int last);
    for (int i = first; i <= last; i++)
      send_word(rtfp_pkg::OP_BYTE, frame_buf[i]);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Header hunting: stray bytes, repeated F4, an error mid-header, ignored mode.
  task automatic test_header_sync();
    send_word(rtfp_pkg::OP_NONE, 8'hFF);
    send_word(rtfp_pkg::OP_BYTE, 8'h00);
    send_word(rtfp_pkg::OP_BYTE, rtfp_pkg::SYNC0);
    send_word(rtfp_pkg::OP_BYTE, rtfp_pkg::SYNC1);
    send_word(rtfp_pkg::OP_BYTE, rtfp_pkg::SYNC0);
    send_word(rtfp_pkg::OP_BYTE, rtfp_pkg::SYNC0);
    send_word(rtfp_pkg::OP_BYTE, rtfp_pkg::SYNC1);
    send_word(rtfp_pkg::OP_BYTE, rtfp_pkg::SYNC2);
    send_word(rtfp_pkg::OP_BYTE, rtfp_pkg::SYNC3);
    build_frame(8'd3, 16'h0120, 8'd100, 16'h0100, 8'd0);
    send_frame_span(int'(rtfp_pkg::POS_LEN_LO), int'(rtfp_pkg::POS_LAST));
    send_word(rtfp_pkg::OP_BYTE, rtfp_pkg::SYNC0);
    send_word(rtfp_pkg::OP_BYTE, rtfp_pkg::SYNC1);
    send_word(rtfp_pkg::OP_BYTE, rtfp_pkg::SYNC2);
    send_word(rtfp_pkg::OP_ERROR, 8'hFF);
    send_word(rtfp_pkg::OP_BYTE, rtfp_pkg::SYNC3);
    send_word(rtfp_pkg::OP_NONE, 8'h00);
  endtask

  // Every target state and the distance choice, with extreme field values.
  task automatic test_target_fields();
    build_frame(8'd1, 16'hFFFF, 8'd100, 16'h1234, 8'd7);
    send_frame_span(0, int'(rtfp_pkg::POS_LAST));
    build_frame(8'd2, 16'h0042, 8'd0, 16'hFFFF, 8'd100);
    send_frame_span(0, int'(rtfp_pkg::POS_LAST));
    build_frame(8'd3, 16'd0, 8'd55, 16'd500, 8'd60);
    send_frame_span(0, int'(rtfp_pkg::POS_LAST));
    build_frame(8'd3, 16'd300, 8'd1, 16'd0, 8'd99);
    send_frame_span(0, int'(rtfp_pkg::POS_LAST));
    build_frame(8'd0, 16'hAAAA, 8'd100, 16'h5555, 8'd100);
    send_frame_span(0, int'(rtfp_pkg::POS_LAST));
  endtask

  // Break one checked byte at a time. A bad length ends the frame at byte
  // six; a bad body byte is caught at the last byte.
  task automatic test_frame_faults();
    for (int p = int'(rtfp_pkg::POS_LEN_LO); p <= int'(rtfp_pkg::POS_LAST); p++) begin
      // data bytes carry no check
      if (p inside {int'(rtfp_pkg::POS_MV_LO), int'(rtfp_pkg::POS_MV_HI),
                    int'(rtfp_pkg::POS_ST_LO), int'(rtfp_pkg::POS_ST_HI),
                    int'(rtfp_pkg::POS_ST_EN) + 1, int'(rtfp_pkg::POS_ST_EN) + 2})
        continue;
      build_random_frame();
      if (p == int'(rtfp_pkg::POS_STATE))
        frame_buf[p] = 8'd4;
      else if (p == int'(rtfp_pkg::POS_MV_EN) || p == int'(rtfp_pkg::POS_ST_EN))
        frame_buf[p] = 8'd101;
      else
        frame_buf[p] = frame_buf[p] ^ 8'h80;
      if (p <= int'(rtfp_pkg::POS_LEN_HI))
        send_frame_span(0, int'(rtfp_pkg::POS_LEN_HI));
      else
        send_frame_span(0, int'(rtfp_pkg::POS_LAST));
    end
  endtask

  // Online window: a timeout of one, zero timeout, and lowering it on the fly.
  task automatic test_online_timeout();
    wait_drained();
    write_timeout(16'd1);
    build_frame(8'd1, 16'd250, 8'd40, 16'd0, 8'd0);
    send_frame_span(0, int'(rtfp_pkg::POS_LAST));
    repeat (3) send_word(rtfp_pkg::OP_TICK, 8'h00);

    wait_drained();
    write_timeout(16'd0);
    build_frame(8'd2, 16'd0, 8'd0, 16'd800, 8'd90);
    send_frame_span(0, int'(rtfp_pkg::POS_LAST));
    send_word(rtfp_pkg::OP_NONE, 8'h3C);
    send_word(rtfp_pkg::OP_TICK, 8'hFF);

    wait_drained();
    write_timeout(rtfp_pkg::TIMEOUT_RESET);
    build_frame(8'd3, 16'd150, 8'd70, 16'd90, 8'd80);
    send_frame_span(0, int'(rtfp_pkg::POS_LAST));
    repeat (5) send_word(rtfp_pkg::OP_TICK, 8'h00);
    // Lower below the current age: online drops at once, fields clear on the next tick.
    wait_drained();
    write_timeout(16'd2);
    send_word(rtfp_pkg::OP_NONE, 8'hA5);
    send_word(rtfp_pkg::OP_ERROR, 8'h5A);
    send_word(rtfp_pkg::OP_TICK, 8'h00);
  endtask

  // Largest timeout: the target stays online through a burst of ticks.
  task automatic test_long_timeout();
    wait_drained();
    write_timeout(16'hFFFF);
    build_frame(8'd3, 16'hFFFF, 8'd100, 16'hFFFF, 8'd100);
    send_frame_span(0, int'(rtfp_pkg::POS_LAST));
    repeat (6) send_word(rtfp_pkg::OP_TICK, 8'($urandom));
  endtask

  // Hold the receiver off while words keep coming so the input stalls.
  task automatic test_output_stall();
    wait_drained();
    write_timeout(rtfp_pkg::TIMEOUT_RESET);
    no_gaps_in = 1'b1;
    hold_request = 60;
    build_random_frame();
    send_frame_span(0, int'(rtfp_pkg::POS_LAST));
    repeat (8) send_word(rtfp_pkg::OP_TICK, 8'($urandom));
    no_gaps_in = 1'b0;
    wait_drained();
  endtask

  // Good frames with random content half of the time, mixed with broken and cut frames,
  // noise, errors and tick bursts; each phase runs at its own timeout.
  task automatic test_random_traffic();
    int stop_at;
    int pick;
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: write_timeout(rtfp_pkg::TIMEOUT_RESET);
        1: write_timeout(16'($urandom_range(1, 12)));
        2: write_timeout(16'd0);
        default: write_timeout(16'hFFFF);
      endcase
      // the first phase runs without any gaps on either side
      no_gaps_in  = (phase == 0);
      no_gaps_out = (phase == 0);
      stop_at = words_sent + ((phase == 0) ? 24 : 8);
      while (words_sent < stop_at) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          build_random_frame();
          send_frame_span(0, int'(rtfp_pkg::POS_LAST));
        end else if (pick < 60) begin
          build_random_frame();
          frame_buf[$urandom_range(int'(rtfp_pkg::POS_LEN_LO), int'(rtfp_pkg::POS_LAST))] =
            8'($urandom);
          send_frame_span(0, int'(rtfp_pkg::POS_LAST));
        end else if (pick < 68) begin
          build_random_frame();
          send_frame_span(0, $urandom_range(0, int'(rtfp_pkg::POS_LAST) - 1));
        end else if (pick < 78) begin
          repeat ($urandom_range(1, 6))
            send_word(rtfp_pkg::OP_BYTE,
                      ($urandom_range(3) == 0) ? rtfp_pkg::SYNC0 : 8'($urandom));
        end else if (pick < 84) begin
          send_word(rtfp_pkg::OP_ERROR, 8'($urandom));
        end else if (pick < 96) begin
          repeat ($urandom_range(1, 10)) send_word(rtfp_pkg::OP_TICK, 8'($urandom));
        end else begin
          send_word(rtfp_pkg::OP_NONE, 8'($urandom));
        end
      end
    end
    no_gaps_in  = 1'b0;
    no_gaps_out = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    mode        = rtfp_pkg::OP_NONE;
    data_byte   = 8'h00;
    out_ready   = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 16'h0000;
    for (int i = 0; i < int'(rtfp_pkg::FRAME_LEN); i++)
      frame_copy[i] = 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_header_sync();
    test_target_fields();
    test_frame_faults();
    test_online_timeout();
    test_long_timeout();
    test_output_stall();
    test_random_traffic();

    wait_drained();
    repeat (6) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
src/rtfp_pkg.sv
src/rtfp_front.sv
src/rtfp_back.sv
src/radar_target_frame_parser.sv
src/rtfp_checker.sv
sim/tb_radar_target_frame_parser.sv
